// ----- hdl/matrix3_inverse_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse unit
// Shared helpers for concurrent checks, clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3_INVERSE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MI3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MI3_ASSERT(lbl, prop, msg)
`define MI3_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/mi3_pkg.sv -----
// ---------------------------------------------------------------------------
// mi3_pkg
// Types shared by the matrix inverse pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;

    typedef struct packed {
        logic valid;
        logic singular;
    } side_t;

endpackage
`default_nettype wire

// ----- hdl/mi3_cofactor.sv -----
// ---------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the 2x2 minor products, then the signed cofactors.
// ---------------------------------------------------------------------------
`default_nettype none
module mi3_cofactor #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   elem [9],
    output logic                  out_valid,
    output logic signed [2*W+1:0] cof [3][3],
    output logic signed [W-1:0]   row0 [3]
);
    localparam int MW = 2 * W + 2;

    logic signed [2*W-1:0] prod_reg [3][3][2];
    logic signed [W-1:0]   e0a_reg [3];
    logic signed [W-1:0]   e0b_reg [3];
    logic signed [MW-1:0]  cof_reg [3][3];
    logic                  v1_reg;
    logic                  v2_reg;

    function automatic int lo_idx(input int i);
        return (i == 0) ? 1 : 0;
    endfunction

    function automatic int hi_idx(input int i);
        return (i == 2) ? 1 : 2;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c][0] <= elem[lo_idx(r) * 3 + lo_idx(c)]
                                       * elem[hi_idx(r) * 3 + hi_idx(c)];
                    prod_reg[r][c][1] <= elem[lo_idx(r) * 3 + hi_idx(c)]
                                       * elem[hi_idx(r) * 3 + lo_idx(c)];
                end
                e0a_reg[r] <= elem[r];
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (((r + c) % 2) == 1) begin
                        cof_reg[r][c] <= MW'(prod_reg[r][c][1]) - MW'(prod_reg[r][c][0]);
                    end else begin
                        cof_reg[r][c] <= MW'(prod_reg[r][c][0]) - MW'(prod_reg[r][c][1]);
                    end
                end
                e0b_reg[r] <= e0a_reg[r];
            end
        end
    end

    assign out_valid = v2_reg;
    assign cof       = cof_reg;
    assign row0      = e0b_reg;
endmodule
`default_nettype wire

// ----- hdl/mi3_det.sv -----
// ---------------------------------------------------------------------------
// mi3_det
// Determinant in split partial products, then divider operands per element.
// ---------------------------------------------------------------------------
`default_nettype none
module mi3_det #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [2*W+1:0]           cof [3][3],
    input  logic signed [W-1:0]             row0 [3],
    input  logic [15:0]                     thr,
    output mi3_pkg::side_t                  side,
    output logic [3*W+2*F+3:0]              num [9],
    output logic [3*W+2:0]                  den,
    output logic                            neg [9]
);
    localparam int MW   = 2 * W + 2;
    localparam int DW   = 3 * W + 2;
    localparam int DENW = DW + 1;
    localparam int NUMW = DW + 2 * F + 2;
    localparam int CMPW = DW + 2 * F + 16;

    logic signed [2*W:0]   pl_reg [3];
    logic signed [2*W+1:0] ph_reg [3];
    logic signed [MW-1:0]  cm_reg [3][3];
    logic signed [MW-1:0]  cs_reg [3][3];
    logic signed [DW-1:0]  det_reg;
    logic [NUMW-1:0]       num_reg [9];
    logic [DENW-1:0]       den_reg;
    logic                  neg_reg [9];
    logic                  sing_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic signed [DW-1:0]  det_sum;
    logic [DW-1:0]         adet;
    logic [MW-1:0]         an [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        det_sum = '0;
        for (int c = 0; c < 3; c++) begin
            det_sum = det_sum + (DW'(ph_reg[c]) <<< W) + DW'(pl_reg[c]);
        end
        adet = det_reg[DW-1] ? (~det_reg + DW'(1)) : det_reg;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                an[r * 3 + c] = cs_reg[c][r][MW-1] ? (~cs_reg[c][r] + MW'(1))
                                                   : cs_reg[c][r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                pl_reg[c] <= row0[c] * $signed({1'b0, cof[0][c][W-1:0]});
                ph_reg[c] <= row0[c] * $signed(cof[0][c][MW-1:W]);
            end
            cm_reg  <= cof;
            cs_reg  <= cm_reg;
            det_reg <= det_sum;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    num_reg[r * 3 + c] <= (NUMW'(an[r * 3 + c]) << (2 * F + 1))
                                        + NUMW'(adet);
                    neg_reg[r * 3 + c] <= cs_reg[c][r][MW-1] ^ det_reg[DW-1];
                end
            end
            den_reg  <= DENW'(adet) << 1;
            sing_reg <= CMPW'(adet) <= (CMPW'(thr) << (2 * F));
        end
    end

    assign side.valid    = v3_reg;
    assign side.singular = sing_reg;
    assign num           = num_reg;
    assign den           = den_reg;
    assign neg           = neg_reg;
endmodule
`default_nettype wire

// ----- hdl/mi3_divider.sv -----
// ---------------------------------------------------------------------------
// mi3_divider
// Restoring divider, one quotient bit per stage, with saturation.
// ---------------------------------------------------------------------------
`default_nettype none
module mi3_divider #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [3*W+2*F+3:0]   num,
    input  logic [3*W+2:0]       den,
    input  logic                 neg,
    output logic [W-1:0]         elem,
    output logic                 ovf
);
    localparam int NUMW = 3 * W + 2 * F + 4;
    localparam int DENW = 3 * W + 3;
    localparam int XW   = (NUMW > DENW + W + 2) ? NUMW : DENW + W + 2;
    localparam int S    = W + 2;

    logic [XW-1:0]   rem_reg [S+1];
    logic [DENW-1:0] den_reg [S+1];
    logic [W+1:0]    q_reg   [S+1];
    logic            neg_reg [S+1];
    logic [W:0]      lim;
    logic [W:0]      mag;
    logic [W:0]      val;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= XW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_step
        logic [XW-1:0] dsh;
        logic          ge;
        assign dsh = XW'(den_reg[k]) << (W + 1 - k);
        assign ge  = rem_reg[k] >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? (rem_reg[k] - dsh) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | ((W + 2)'(ge) << (W + 1 - k));
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_comb begin
        lim  = ((W + 1)'(1) << (W - 1)) - (W + 1)'(!neg_reg[S]);
        ovf  = q_reg[S][W+1] | (q_reg[S][W:0] > lim);
        mag  = ovf ? lim : q_reg[S][W:0];
        val  = neg_reg[S] ? (~mag + (W + 1)'(1)) : mag;
        elem = val[W-1:0];
    end
endmodule
`default_nettype wire

// ----- hdl/matrix3_inverse_unit.sv -----
// ---------------------------------------------------------------------------
// matrix3_inverse_unit
// 3x3 matrix inverse by adjugate and determinant, fully pipelined.
// ---------------------------------------------------------------------------
// Channel   Direction  Ports                        Content
// s_        in         s_tvalid/s_tready/s_tdata    nine elements a00..a22
// m_        out        m_tvalid/m_tready/m_tdata    nine elements r00..r22
//                      m_tuser                      singular, overflow
// cfg_      in         cfg_we/cfg_wdata             singular threshold
//
// One matrix is taken per cycle unless the pipeline holds. The depth is set
// mostly by the divider, which resolves one quotient bit per stage; the result
// then passes through the output buffer.
// Reset clears all valid bits and the output buffer; the threshold resets to 0.
// A two-entry output buffer lets requests enter while a result waits; the
// whole pipeline holds only when that buffer is full and m_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "matrix3_inverse_unit_defines.svh"
module matrix3_inverse_unit #(
    parameter  int ELEM_WIDTH = 32,
    parameter  int FRAC_BITS  = 16,
    localparam int TDW        = ((9 * ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [TDW-1:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [TDW-1:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [1:0]     m_tuser,   // singular, overflow
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);
    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LAT  = W + 3;
    localparam int PLW  = TDW + 2;

    logic                   en;
    logic [15:0]            thr_reg;
    logic signed [W-1:0]    elem [9];
    logic                   cof_valid;
    logic signed [2*W+1:0]  cof [3][3];
    logic signed [W-1:0]    row0 [3];
    mi3_pkg::side_t         det_side;
    logic [3*W+2*F+3:0]     num [9];
    logic [3*W+2:0]         den;
    logic                   neg [9];
    mi3_pkg::side_t         side_reg [LAT];
    logic [W-1:0]           q_elem [9];
    logic                   q_ovf [9];
    logic [PLW-1:0]         res;
    logic                   push;
    logic                   pop;
    logic [PLW-1:0]         head_reg;
    logic [PLW-1:0]         head_next;
    logic [PLW-1:0]         tail_reg;
    logic [PLW-1:0]         tail_next;
    logic [1:0]             count_reg;
    logic [1:0]             count_next;

    assign en       = (count_reg != 2'd2) || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            elem[k] = s_tdata[k*W +: W];
        end
    end

    mi3_cofactor #(.W(W)) u_cof (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .elem      (elem),
        .out_valid (cof_valid),
        .cof       (cof),
        .row0      (row0)
    );

    mi3_det #(.W(W), .F(F)) u_det (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cof_valid),
        .cof      (cof),
        .row0     (row0),
        .thr      (thr_reg),
        .side     (det_side),
        .num      (num),
        .den      (den),
        .neg      (neg)
    );

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_divider #(.W(W), .F(F)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num[k]),
            .den  (den),
            .neg  (neg[k]),
            .elem (q_elem[k]),
            .ovf  (q_ovf[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= det_side;
            for (int i = 1; i < LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb begin
        res = '0;
        for (int k = 0; k < 9; k++) begin
            if (!side_reg[LAT-1].singular) begin
                res[k*W +: W] = q_elem[k];
                res[TDW+1]    = res[TDW+1] | q_ovf[k];
            end
        end
        res[TDW] = side_reg[LAT-1].singular;
    end

    assign push = side_reg[LAT-1].valid && en;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next  = res;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = res;
                end else if (pop) begin
                    count_next = 2'd0;
                end else if (push) begin
                    tail_next  = res;
                    count_next = 2'd2;
                end
            end
            default: begin
                if (pop) begin
                    head_next = tail_reg;
                    if (push) begin
                        tail_next = res;
                    end else begin
                        count_next = 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = head_reg[TDW-1:0];
    assign m_tuser  = head_reg[TDW+1:TDW];

    `MI3_ASSERT(a_sing_zero, m_tvalid && m_tuser[0] |-> m_tuser[1] == 1'b0 && m_tdata == '0, "singular result not cleared")
    `MI3_ASSERT(a_no_overfill, count_reg == 2'd2 && !m_tready |=> count_reg == 2'd2 && $stable(head_reg), "output buffer lost a result")
    `MI3_ASSERT(a_count_range, count_reg != 2'd3, "output buffer count out of range")
    `MI3_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> count_reg == 2'd0, "output buffer not empty after reset")
endmodule
`default_nettype wire

// ----- dv/matrix3_inverse_checker.sv -----
// ---------------------------------------------------------------------------
// Checker for the 3x3 matrix inverse unit
// Watches the request, result and threshold ports, works out the expected
// rounded and saturated inverse of every accepted matrix and compares it with each result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module matrix3_inverse_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [287:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [287:0] m_tdata,
    input  wire [1:0]   m_tuser,
    input  wire         cfg_we,
    input  wire [15:0]  cfg_wdata,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [287:0] elems;
        logic         singular;
        logic         overflow;
    } inverse_t;

    inverse_t    awaited_inverses[$];
    logic [15:0] threshold;

    function automatic inverse_t invert_matrix(logic [287:0] d, logic [15:0] thr);
        logic signed [255:0] e [3][3];
        logic signed [255:0] cof [3][3];
        logic signed [255:0] det;
        logic signed [255:0] n;
        logic [255:0]        adet;
        logic [255:0]        mag;
        logic [255:0]        quo;
        logic [255:0]        limit;
        logic [31:0]         val;
        logic                neg;
        int                  r1, r2, c1, c2;
        inverse_t            res;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                e[r][c] = signed'(d[32*(r*3+c) +: 32]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                n = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
                cof[r][c] = ((r + c) % 2 == 1) ? -n : n;
            end
        end
        det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
        adet = det[255] ? -det : det;
        res.elems = '0;
        res.overflow = 1'b0;
        res.singular = 1'b0;
        if (adet <= ({240'd0, thr} << 32)) begin
            res.singular = 1'b1;
            return res;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n = cof[c][r];
                neg = n[255] ^ det[255];
                mag = n[255] ? -n : n;
                quo = ((mag << 33) + adet) / (adet << 1);
                limit = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
                if (quo > limit) begin
                    res.overflow = 1'b1;
                    quo = limit;
                end
                val = neg ? -quo[31:0] : quo[31:0];
                res.elems[32*(r*3+c) +: 32] = val;
            end
        end
        return res;
    endfunction

    assign pending = awaited_inverses.size();

    always @(posedge aclk) begin
        inverse_t want;
        int       fails;
        fails = 0;
        if (!aresetn) begin
            threshold <= '0;
            errors <= 0;
            awaited_inverses.delete();
        end else begin
            if (cfg_we) begin
                threshold <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                awaited_inverses.push_back(invert_matrix(s_tdata, threshold));
            end
            if (m_tvalid && m_tready) begin
                if (awaited_inverses.size() == 0) begin
                    $display("%0t: unexpected result %h user %b", $time, m_tdata, m_tuser);
                    fails = fails + 1;
                end else begin
                    want = awaited_inverses.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (m_tdata[32*i +: 32] !== want.elems[32*i +: 32]) begin
                            $display("%0t: element r%0d%0d expected %h actual %h", $time,
                                     i / 3, i % 3, want.elems[32*i +: 32], m_tdata[32*i +: 32]);
                            fails = fails + 1;
                        end
                    end
                    if (m_tuser[0] !== want.singular) begin
                        $display("%0t: singular expected %b actual %b", $time,
                                 want.singular, m_tuser[0]);
                        fails = fails + 1;
                    end
                    if (m_tuser[1] !== want.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want.overflow, m_tuser[1]);
                        fails = fails + 1;
                    end
                end
            end
            errors <= errors + fails;
        end
    end

endmodule
`default_nettype wire

// ----- dv/tb_matrix3_inverse_unit.sv -----
// ---------------------------------------------------------------------------
// Testbench for the 3x3 matrix inverse unit
// Sends directed and random matrices in bursts under a stalling receiver,
// over several singular thresholds, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix3_inverse_unit;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] MINUS1  = 32'hFFFF_0000;
    localparam logic [31:0] MAXELEM = 32'h7FFF_FFFF;
    localparam logic [31:0] MINELEM = 32'h8000_0000;
    localparam int          WATCHDOG_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    int           errors;
    int           pending;
    int           burst_left = 0;
    int           idle_cycles = 0;
    int           cycle_count = 0;

    always #5 aclk = ~aclk;

    matrix3_inverse_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    matrix3_inverse_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // The receiver alternates between always ready, light stalls and heavy stalls.
    always @(posedge aclk) begin
        int mode;
        cycle_count <= cycle_count + 1;
        mode = (cycle_count / 300) % 3;
        if (mode == 0) begin
            m_tready <= 1'b1;
        end else if (mode == 1) begin
            m_tready <= ($urandom_range(0, 99) >= 25);
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 80);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_matrix3_inverse_unit: errors");
            $finish;
        end
    end

    task automatic send_request(input logic [287:0] m);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= m;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        burst_left--;
    endtask

    task automatic drain_pipeline();
        burst_left = 0;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [287:0] pack_matrix(input logic [31:0] a00, a01, a02,
                                                 a10, a11, a12, a20, a21, a22);
        return {a22, a21, a20, a12, a11, a10, a02, a01, a00};
    endfunction

    function automatic logic [31:0] small_elem();
        return 32'($urandom_range(0, 1048576)) - 32'd524288;
    endfunction

    function automatic logic [287:0] random_matrix();
        logic [287:0] m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            m[32*i +: 32] = (kind < 2) ? $urandom() : small_elem();
        end
        if (kind == 2) begin
            m[64 +: 96] = m[0 +: 96];
        end else if (kind == 3) begin
            for (int i = 0; i < 9; i++) m[32*i +: 32] = 32'($urandom_range(0, 6)) - 32'd3;
        end else if (kind == 4) begin
            m[32*$urandom_range(0, 8) +: 32] = $urandom_range(0, 1) ? MAXELEM : MINELEM;
        end
        return m;
    endfunction

    task automatic threshold_edges(input logic [15:0] thr);
        send_request(pack_matrix({16'd0, thr}, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_request(pack_matrix({16'd0, thr} + 1, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_request(pack_matrix(-{16'd0, thr}, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_request(pack_matrix(-{16'd0, thr} - 1, 0, 0, 0, ONE, 0, 0, 0, ONE));
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(random_matrix());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request('0);
        send_request(pack_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_request(pack_matrix(MINUS1, 0, 0, 0, MINUS1, 0, 0, 0, MINUS1));
        send_request(pack_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_request(pack_matrix(MAXELEM, 0, 0, 0, MAXELEM, 0, 0, 0, MAXELEM));
        send_request(pack_matrix(MINELEM, 0, 0, 0, MINELEM, 0, 0, 0, MINELEM));
        send_request({9{MAXELEM}});
        send_request({9{MINELEM}});
        send_request(pack_matrix(MINELEM, MAXELEM, 0, MAXELEM, MINELEM, 0, 0, 0, 1));
        send_request(pack_matrix(32'd2, ONE, 0, 0, 32'd3, 0, 0, 0, ONE));
        send_request(pack_matrix(32'd3, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_request(pack_matrix(ONE, 32'd2 * ONE, 32'd3 * ONE, 32'd4 * ONE, 32'd5 * ONE,
                                 32'd6 * ONE, 32'd7 * ONE, 32'd8 * ONE, 32'd10 * ONE));
        send_request(pack_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
        threshold_edges(16'd0);
        random_phase(100);
        drain_pipeline();

        write_threshold(16'hFFFF);
        threshold_edges(16'hFFFF);
        random_phase(60);
        drain_pipeline();
        random_phase(60);
        drain_pipeline();

        write_threshold(16'($urandom_range(2, 65534)));
        random_phase(100);
        drain_pipeline();

        write_threshold(16'd1);
        threshold_edges(16'd1);
        random_phase(100);
        drain_pipeline();

        if (errors == 0) begin
            $display("tb_matrix3_inverse_unit: clean");
        end else begin
            $display("tb_matrix3_inverse_unit: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
